>>> src/jpid_pkg.sv
// shared types and constants for the joint pid torque controller
// no dependencies; imported by every module of the block

package jpid_pkg;

  // register file index codes
  typedef enum logic [2:0] {
    CFG_GAIN_P     = 3'd0,
    CFG_GAIN_I     = 3'd1,
    CFG_GAIN_D     = 3'd2,
    CFG_TORQUE_MIN = 3'd3,
    CFG_TORQUE_MAX = 3'd4,
    CFG_ANGLE_MIN  = 3'd5,
    CFG_ANGLE_MAX  = 3'd6
  } cfg_idx_e;

  // which torque limit was applied
  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_LOW  = 2'd1,
    CLAMP_HIGH = 2'd2
  } clamp_e;

  // reset values of the limit registers
  localparam logic signed [31:0] LIMIT_LOW_RST  = 32'sh8000_0000;
  localparam logic signed [31:0] LIMIT_HIGH_RST = 32'sh7fff_ffff;

  // integrator saturation bounds, q32.16
  localparam logic signed [47:0] ACC_MAX = 48'sh7fff_ffff_ffff;
  localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

  // input transaction
  typedef struct packed {
    logic               op;
    logic signed [31:0] target_angle;
    logic signed [31:0] measured_angle;
    logic signed [31:0] target_velocity;
    logic signed [31:0] measured_velocity;
  } jpid_in_t;

  // result transaction
  typedef struct packed {
    logic signed [31:0] torque;
    clamp_e             clamp_state;
  } jpid_out_t;

  // configuration registers, all q16.16
  typedef struct packed {
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic signed [31:0] torque_min;
    logic signed [31:0] torque_max;
    logic signed [31:0] angle_min;
    logic signed [31:0] angle_max;
  } jpid_cfg_t;

  // error stage result: position error, velocity error, updated integrator
  typedef struct packed {
    logic               clr;
    logic signed [32:0] err;
    logic signed [32:0] verr;
    logic signed [47:0] acc;
  } jpid_err_t;

  // the three exact gain products in q.32
  typedef struct packed {
    logic               clr;
    logic signed [64:0] p_prod;
    logic signed [79:0] i_prod;
    logic signed [64:0] d_prod;
  } jpid_prod_t;

endpackage

>>> src/jpid_err_stage.sv
// input register, target angle clamp, error forming and integrator state
// depends on jpid_pkg

module jpid_err_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_fire_i,
  input  jpid_pkg::jpid_in_t   in_data_i,
  input  jpid_pkg::jpid_cfg_t  cfg_i,
  output logic                 valid_o,
  output jpid_pkg::jpid_err_t  err_o
);
  import jpid_pkg::*;

  logic               in_valid_q;
  jpid_in_t           in_q;
  logic signed [47:0] integ_q;
  logic signed [32:0] prev_err_q;
  logic               s2_valid_q;
  jpid_err_t          s2_q;

  logic signed [31:0] tgt;
  logic signed [32:0] err;
  logic signed [32:0] verr;
  logic signed [48:0] acc_sum;
  logic signed [47:0] acc;

  // clamp target, form errors, saturating integrator add
  always_comb begin
    tgt = in_q.target_angle;
    if (tgt < cfg_i.angle_min) begin
      tgt = cfg_i.angle_min;
    end
    if (cfg_i.angle_max < tgt) begin
      tgt = cfg_i.angle_max;
    end
    err  = 33'(tgt) - 33'(in_q.measured_angle);
    verr = 33'(in_q.target_velocity) - 33'(in_q.measured_velocity);

    acc_sum = 49'(integ_q) + 49'(prev_err_q);
    if (acc_sum > 49'(ACC_MAX)) begin
      acc = ACC_MAX;
    end else if (acc_sum < 49'(ACC_MIN)) begin
      acc = ACC_MIN;
    end else begin
      acc = acc_sum[47:0];
    end
  end

  // control and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      integ_q    <= '0;
      prev_err_q <= '0;
    end else if (en_i) begin
      in_valid_q <= in_fire_i;
      s2_valid_q <= in_valid_q;
      if (in_valid_q) begin
        if (in_q.op) begin
          integ_q    <= '0;
          prev_err_q <= '0;
        end else begin
          integ_q    <= acc;
          prev_err_q <= err;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (in_fire_i) begin
        in_q <= in_data_i;
      end
      s2_q.clr  <= in_q.op;
      s2_q.err  <= err;
      s2_q.verr <= verr;
      s2_q.acc  <= acc;
    end
  end

  assign valid_o = s2_valid_q;
  assign err_o   = s2_q;

  // a clear transaction zeroes the stored state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && in_valid_q && in_q.op |=> integ_q == '0 && prev_err_q == '0)
    else $error("controller state not cleared");

  // state only moves when a transaction passes the error stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(en_i && in_valid_q) |=> $stable(integ_q) && $stable(prev_err_q))
    else $error("controller state changed without a transaction");

endmodule

>>> src/jpid_mul_stage.sv
// gain multiplies split into partial products, then recombined
// depends on jpid_pkg

module jpid_mul_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  jpid_pkg::jpid_err_t  err_i,
  input  jpid_pkg::jpid_cfg_t  cfg_i,
  output logic                 valid_o,
  output jpid_pkg::jpid_prod_t prod_o
);
  import jpid_pkg::*;

  // partial products: signed high slice and unsigned low 16 bits
  typedef struct packed {
    logic               clr;
    logic signed [48:0] p_hi;
    logic signed [48:0] p_lo;
    logic signed [63:0] i_hi;
    logic signed [48:0] i_lo;
    logic signed [48:0] d_hi;
    logic signed [48:0] d_lo;
  } pp_t;

  logic       s3_valid_q;
  pp_t        s3_q;
  pp_t        s3_d;
  logic       s4_valid_q;
  jpid_prod_t s4_q;
  jpid_prod_t s4_d;

  // one 32-bit multiply per partial product
  always_comb begin
    s3_d.clr  = err_i.clr;
    s3_d.p_hi = cfg_i.gain_p * $signed(err_i.err[32:16]);
    s3_d.p_lo = cfg_i.gain_p * $signed({1'b0, err_i.err[15:0]});
    s3_d.i_hi = cfg_i.gain_i * $signed(err_i.acc[47:16]);
    s3_d.i_lo = cfg_i.gain_i * $signed({1'b0, err_i.acc[15:0]});
    s3_d.d_hi = cfg_i.gain_d * $signed(err_i.verr[32:16]);
    s3_d.d_lo = cfg_i.gain_d * $signed({1'b0, err_i.verr[15:0]});
  end

  // recombine each product from its two halves
  always_comb begin
    s4_d.clr    = s3_q.clr;
    s4_d.p_prod = (65'(s3_q.p_hi) <<< 16) + 65'(s3_q.p_lo);
    s4_d.i_prod = (80'(s3_q.i_hi) <<< 16) + 80'(s3_q.i_lo);
    s4_d.d_prod = (65'(s3_q.d_hi) <<< 16) + 65'(s3_q.d_lo);
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q <= valid_i;
      s4_valid_q <= s3_valid_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  assign valid_o = s4_valid_q;
  assign prod_o  = s4_q;

endmodule

>>> src/jpid_out_stage.sv
// product sum, rescale to q16.16, torque clamp, output register with skid
// depends on jpid_pkg

module jpid_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  jpid_pkg::jpid_prod_t  prod_i,
  input  jpid_pkg::jpid_cfg_t   cfg_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output jpid_pkg::jpid_out_t   out_data_o,
  output logic                  hold_o
);
  import jpid_pkg::*;

  logic               s5_valid_q;
  logic               s5_clr_q;
  logic signed [65:0] s5_sum_q;
  logic signed [81:0] sum_full;

  logic               out_valid_q;
  jpid_out_t          out_q;
  logic               skid_valid_q;
  jpid_out_t          skid_q;

  logic signed [65:0] res;
  jpid_out_t          res_data;
  logic               out_fire;
  logic               take_new;
  logic               to_skid;

  // exact three-term sum, floor shift by 16
  assign sum_full = 82'(prod_i.p_prod) + 82'(prod_i.i_prod) + 82'(prod_i.d_prod);

  // low limit first, then high limit
  always_comb begin
    res                  = s5_sum_q;
    res_data.clamp_state = CLAMP_NONE;
    if (res < 66'(cfg_i.torque_min)) begin
      res                  = 66'(cfg_i.torque_min);
      res_data.clamp_state = CLAMP_LOW;
    end
    if (66'(cfg_i.torque_max) < res) begin
      res                  = 66'(cfg_i.torque_max);
      res_data.clamp_state = CLAMP_HIGH;
    end
    res_data.torque = res[31:0];
    if (s5_clr_q) begin
      res_data.torque      = '0;
      res_data.clamp_state = CLAMP_NONE;
    end
  end

  // output handshake steering
  assign out_fire = out_valid_q && !out_stall_i;
  assign take_new = en_i && s5_valid_q;
  assign to_skid  = take_new && out_valid_q && out_stall_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (en_i) begin
        s5_valid_q <= valid_i;
      end
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (take_new) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= to_skid;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_clr_q <= prod_i.clr;
      s5_sum_q <= sum_full[81:16];
    end
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (take_new) begin
      if (to_skid) begin
        skid_q <= res_data;
      end else begin
        out_q <= res_data;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign hold_o      = skid_valid_q;

  // skid entry only exists behind a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds data with output empty");

  // a stalled output keeps its skid entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_stall_i |=> skid_valid_q && $stable(skid_q))
    else $error("skid entry lost under stall");

endmodule

>>> src/joint_pid_torque_controller.sv
// top level of the joint pid torque controller: register file and pipeline
// depends on jpid_pkg, jpid_err_stage, jpid_mul_stage, jpid_out_stage
//
// usage:
//   input channel  in_valid_i / in_stall_o / in_data_i carries one control tick
//   (op, target and measured angle, target and measured velocity, q16.16)
//   output channel out_valid_o / out_stall_i / out_data_o returns one result
//   (clamped torque and clamp_state) per input transaction, in order
//   configuration channel cfg_valid_i / cfg_ready_o writes cfg_data_i into
//   register cfg_index_i; ready is always high, unknown indexes are dropped
// path: a tick passes the input, s2, s3, s4 and s5 registers, then the output or skid register
// throughput: one transaction per cycle while in_stall_o is low; the six-stage
//   pipeline advances as a whole, the integrator update sits in a single stage
//   so consecutive ticks need no spacing
// stall: a result waiting under out_stall_i does not stop the pipe; the next
//   result goes to a skid register; once that is full in_stall_o rises
//   and the pipe holds until the output is taken
// reset: gains clear to zero, limits open to the full 32-bit range,
//   integrator and stored error clear, all pipeline valids drop

module joint_pid_torque_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  jpid_pkg::jpid_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output jpid_pkg::jpid_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import jpid_pkg::*;

  jpid_cfg_t  cfg_q;
  logic       en;
  logic       hold;
  logic       in_fire;
  logic       err_valid;
  jpid_err_t  err_res;
  logic       prod_valid;
  jpid_prod_t prod_res;

  // register file writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p     <= '0;
      cfg_q.gain_i     <= '0;
      cfg_q.gain_d     <= '0;
      cfg_q.torque_min <= LIMIT_LOW_RST;
      cfg_q.torque_max <= LIMIT_HIGH_RST;
      cfg_q.angle_min  <= LIMIT_LOW_RST;
      cfg_q.angle_max  <= LIMIT_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN_P:     cfg_q.gain_p     <= cfg_data_i;
        CFG_GAIN_I:     cfg_q.gain_i     <= cfg_data_i;
        CFG_GAIN_D:     cfg_q.gain_d     <= cfg_data_i;
        CFG_TORQUE_MIN: cfg_q.torque_min <= cfg_data_i;
        CFG_TORQUE_MAX: cfg_q.torque_max <= cfg_data_i;
        CFG_ANGLE_MIN:  cfg_q.angle_min  <= cfg_data_i;
        CFG_ANGLE_MAX:  cfg_q.angle_max  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advance and input handshake
  assign cfg_ready_o = 1'b1;
  assign en          = !hold;
  assign in_stall_o  = hold;
  assign in_fire     = in_valid_i && !hold;

  jpid_err_stage u_err (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_fire_i (in_fire),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .valid_o   (err_valid),
    .err_o     (err_res)
  );

  jpid_mul_stage u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (err_valid),
    .err_i   (err_res),
    .cfg_i   (cfg_q),
    .valid_o (prod_valid),
    .prod_o  (prod_res)
  );

  jpid_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (prod_valid),
    .prod_i      (prod_res),
    .cfg_i       (cfg_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .hold_o      (hold)
  );

  // input side only stalls while a result is waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

>>> test/jpid_torque_checker.sv
`timescale 1ns / 100ps
// result checker for the joint pid torque controller: follows the config, input
// and result channels, predicts every result transaction and compares it
// depends on jpid_pkg only

module jpid_torque_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  jpid_pkg::jpid_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  jpid_pkg::jpid_out_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output int                  mismatch_count_o,
  output int                  pending_o
);

  import jpid_pkg::*;

  // one predicted tick: the result plus the controller state after it
  typedef struct packed {
    jpid_out_t          res;
    logic signed [47:0] integ;
    logic signed [32:0] perr;
  } pid_tick_t;

  jpid_cfg_t          regs;
  logic signed [47:0] integ_q;
  logic signed [32:0] perr_q;
  jpid_out_t          expected_torques[$];

  // exact pid law: target clamp, saturating integrator, wide sum, floor shift, torque clamp
  function automatic pid_tick_t pid_torque_tick(input jpid_in_t t, input jpid_cfg_t c,
                                                input logic signed [47:0] integ,
                                                input logic signed [32:0] perr);
    logic signed [49:0] acc_w;
    logic signed [47:0] acc;
    logic signed [31:0] tgt;
    logic signed [32:0] err;
    logic signed [32:0] verr;
    logic signed [95:0] sum;
    logic signed [95:0] lo;
    logic signed [95:0] hi;
    pid_tick_t          r;
    r.res.torque      = '0;
    r.res.clamp_state = CLAMP_NONE;
    r.integ           = '0;
    r.perr            = '0;
    if (t.op) begin
      return r;
    end
    // target clamp, low limit first so crossed limits end at angle_max
    tgt = $signed(t.target_angle);
    if (tgt < $signed(c.angle_min)) tgt = $signed(c.angle_min);
    if (tgt > $signed(c.angle_max)) tgt = $signed(c.angle_max);
    // integrator takes the error of the previous tick
    acc_w = $signed(integ) + $signed(perr);
    if (acc_w > $signed(ACC_MAX)) acc = ACC_MAX;
    else if (acc_w < $signed(ACC_MIN)) acc = ACC_MIN;
    else acc = acc_w[47:0];
    err  = $signed(tgt) - $signed(t.measured_angle);
    verr = $signed(t.target_velocity) - $signed(t.measured_velocity);
    sum  = $signed(c.gain_p) * err + $signed(c.gain_i) * acc + $signed(c.gain_d) * verr;
    sum  = sum >>> 16;
    // torque clamp, high limit wins when the limits are crossed
    lo = $signed(c.torque_min);
    hi = $signed(c.torque_max);
    if (sum < lo) begin
      sum               = lo;
      r.res.clamp_state = CLAMP_LOW;
    end
    if (sum > hi) begin
      sum               = hi;
      r.res.clamp_state = CLAMP_HIGH;
    end
    r.res.torque = sum[31:0];
    r.integ      = acc;
    r.perr       = err;
    return r;
  endfunction

  // follow config writes, predict on input transactions, compare on results
  always @(posedge clk_i or negedge rst_ni) begin : watch
    jpid_out_t want;
    pid_tick_t nxt;
    if (!rst_ni) begin
      regs.gain_p      = '0;
      regs.gain_i      = '0;
      regs.gain_d      = '0;
      regs.torque_min  = LIMIT_LOW_RST;
      regs.torque_max  = LIMIT_HIGH_RST;
      regs.angle_min   = LIMIT_LOW_RST;
      regs.angle_max   = LIMIT_HIGH_RST;
      integ_q          = '0;
      perr_q           = '0;
      expected_torques.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_GAIN_P:     regs.gain_p     = cfg_data_i;
          CFG_GAIN_I:     regs.gain_i     = cfg_data_i;
          CFG_GAIN_D:     regs.gain_d     = cfg_data_i;
          CFG_TORQUE_MIN: regs.torque_min = cfg_data_i;
          CFG_TORQUE_MAX: regs.torque_max = cfg_data_i;
          CFG_ANGLE_MIN:  regs.angle_min  = cfg_data_i;
          CFG_ANGLE_MAX:  regs.angle_max  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        nxt     = pid_torque_tick(in_data_i, regs, integ_q, perr_q);
        integ_q = nxt.integ;
        perr_q  = nxt.perr;
        expected_torques.push_back(nxt.res);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_torques.size() == 0) begin
          $display("%0t: unexpected result, actual torque %h clamp_state %0d", $time,
                   out_data_i.torque, out_data_i.clamp_state);
          mismatch_count_o++;
        end else begin
          want = expected_torques.pop_front();
          if (out_data_i.torque !== want.torque) begin
            $display("%0t: torque mismatch, expected %h actual %h", $time,
                     want.torque, out_data_i.torque);
            mismatch_count_o++;
          end
          if (out_data_i.clamp_state !== want.clamp_state) begin
            $display("%0t: clamp_state mismatch, expected %0d actual %0d", $time,
                     want.clamp_state, out_data_i.clamp_state);
            mismatch_count_o++;
          end
        end
      end
    end
    pending_o = expected_torques.size();
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// top of the joint pid torque controller test: clock, reset, config writes,
// control tick stimulus with random idling and the verdict
// depends on jpid_pkg, joint_pid_torque_controller and jpid_torque_checker

module testbench;

  import jpid_pkg::*;

  localparam int          CYCLE_LIMIT       = 600000;
  localparam int          HOLD_CYCLES       = 80;
  localparam int          SETTLE_CYCLES     = 12;
  localparam int          SAT_TICKS         = 40;
  localparam int          TICKS_PER_SETTING = 180;
  localparam logic [2:0]  CFG_UNMAPPED      = 3'd7;
  localparam logic [31:0] Q_ONE             = 32'h0001_0000;
  localparam logic [31:0] Q_MAX             = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN             = 32'h8000_0000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  jpid_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  jpid_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  int   mismatch_count;
  int   pending;
  int   cycles   = 0;
  int   snd_idle = 0;
  int   rcv_idle = 0;
  logic hold_req = 1'b0;

  joint_pid_torque_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  jpid_torque_checker torque_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stall, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  function automatic jpid_in_t tick(input logic op, input logic [31:0] ta, input logic [31:0] ma,
                                    input logic [31:0] tv, input logic [31:0] mv);
    jpid_in_t t;
    t.op                = op;
    t.target_angle      = ta;
    t.measured_angle    = ma;
    t.target_velocity   = tv;
    t.measured_velocity = mv;
    return t;
  endfunction

  // mix of full range, small, medium and edge values in q16.16
  function automatic logic [31:0] pick_field();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(32'h0010_0000) - 32'h0008_0000;
      2: v = $urandom_range(32'h0200_0000) - 32'h0100_0000;
      default: begin
        case ($urandom_range(4))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = '0;
          3: v = '1;
          default: v = 32'd1;
        endcase
      end
    endcase
    return v;
  endfunction

  // mostly gains within +-2.0, now and then zero or full range
  function automatic logic [31:0] pick_gain();
    case ($urandom_range(7))
      0: return $urandom;
      1: return '0;
      default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  // limit pair {low, high}: full range, crossed, or an ordinary window
  function automatic logic [63:0] pick_limits();
    logic [31:0] lo;
    logic [31:0] hi;
    case ($urandom_range(5))
      0: begin
        lo = Q_MIN;
        hi = Q_MAX;
      end
      1: begin
        lo = $urandom_range(32'h0100_0000);
        hi = -$urandom_range(32'h0100_0000);
      end
      default: begin
        lo = -$urandom_range(32'h03e8_0000, 32'h0000_0001);
        hi = $urandom_range(32'h03e8_0000, 32'h0000_0001);
      end
    endcase
    return {lo, hi};
  endfunction

  // one input transaction with a random gap in front
  task automatic send_tick(input jpid_in_t t);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // one config transaction; the caller lowers cfg_valid after a batch
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_setting(input logic [31:0] gp, input logic [31:0] gi,
                               input logic [31:0] gd, input logic [63:0] torque_lim,
                               input logic [63:0] angle_lim);
    write_reg(CFG_GAIN_P, gp);
    write_reg(CFG_GAIN_I, gi);
    write_reg(CFG_GAIN_D, gd);
    write_reg(CFG_TORQUE_MIN, torque_lim[63:32]);
    write_reg(CFG_TORQUE_MAX, torque_lim[31:0]);
    write_reg(CFG_ANGLE_MIN, angle_lim[63:32]);
    write_reg(CFG_ANGLE_MAX, angle_lim[31:0]);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    jpid_in_t t;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: gain 1.0 / 0.0039 / 0.5, torque +-100.0, angle +-10.0
    write_setting(Q_ONE, 32'h0000_0100, 32'h0000_8000, {32'hff9c_0000, 32'h0064_0000},
                  {32'hfff6_0000, 32'h000a_0000});
    send_tick(tick(1'b1, '1, '1, '1, '1));
    send_tick(tick(1'b0, Q_ONE, '0, '0, '0));
    send_tick(tick(1'b0, 32'h0014_0000, '0, 32'h0002_0000, '0));
    send_tick(tick(1'b0, 32'hffec_0000, '0, '0, 32'h0002_0000));
    send_tick(tick(1'b0, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    send_tick(tick(1'b0, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    send_tick(tick(1'b0, '0, '0, '0, '0));
    send_tick(tick(1'b1, '0, '0, '0, '0));
    send_tick(tick(1'b0, 32'h0000_8000, 32'h0000_4000, 32'h0000_0001, '1));
    drain();

    // crossed angle and torque limits
    write_reg(CFG_ANGLE_MIN, 32'h0005_0000);
    write_reg(CFG_ANGLE_MAX, 32'hfffb_0000);
    write_reg(CFG_TORQUE_MIN, 32'h0032_0000);
    write_reg(CFG_TORQUE_MAX, 32'hffce_0000);
    cfg_valid <= 1'b0;
    send_tick(tick(1'b0, '0, '0, '0, '0));
    send_tick(tick(1'b0, Q_MAX, '0, '0, '0));
    send_tick(tick(1'b0, Q_MIN, Q_ONE, Q_MIN, Q_MAX));
    send_tick(tick(1'b0, 32'h0003_0000, 32'hfffe_0000, Q_ONE, '0));
    drain();

    // a write to the unmapped index, extreme gains, open limits, then wind the
    // integrator up with full-scale errors, clear it and wind it down at full rate
    write_reg(CFG_UNMAPPED, 32'h1234_5678);
    write_setting(Q_MAX, Q_MIN, Q_MAX, {Q_MIN, Q_MAX}, {Q_MIN, Q_MAX});
    send_tick(tick(1'b1, '0, '0, '0, '0));
    for (int n = 0; n < SAT_TICKS; n++) begin
      send_tick(tick(1'b0, Q_MAX, Q_MIN, $urandom, $urandom));
    end
    send_tick(tick(1'b1, $urandom, $urandom, $urandom, $urandom));
    for (int n = 0; n < SAT_TICKS; n++) begin
      send_tick(tick(1'b0, Q_MIN, Q_MAX, $urandom, $urandom));
    end
    for (int n = 0; n < 8; n++) begin
      send_tick(tick(1'b0, Q_MAX, Q_MIN, '0, '0));
    end
    drain();

    // random part: idle mix 30/80, then 80/30, then none
    for (int phase = 0; phase < 3; phase++) begin
      snd_idle = (phase == 0) ? 30 : (phase == 1) ? 80 : 0;
      rcv_idle = (phase == 0) ? 80 : (phase == 1) ? 30 : 0;
      for (int s = 0; s < 2; s++) begin
        write_setting(pick_gain(), pick_gain(), pick_gain(), pick_limits(), pick_limits());
        for (int n = 0; n < TICKS_PER_SETTING; n++) begin
          // hold the result side off long enough for the input to stall
          if (phase == 2 && s == 0 && n == TICKS_PER_SETTING / 2) hold_req = 1'b1;
          t = tick($urandom_range(99) < 8, pick_field(), pick_field(), pick_field(),
                   pick_field());
          // half the time keep the target near the measured angle
          if ($urandom_range(1)) begin
            t.target_angle = t.measured_angle + ($urandom_range(32'h0008_0000) - 32'h0004_0000);
          end
          send_tick(t);
        end
        drain();
      end
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/jpid_pkg.sv
src/jpid_err_stage.sv
src/jpid_mul_stage.sv
src/jpid_out_stage.sv
src/joint_pid_torque_controller.sv
test/jpid_torque_checker.sv
test/testbench.sv
